FILE: src/fsrq_pkg.sv
`default_nettype none
package fsrq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int ID_W = 16;
	localparam int RT_W = 64;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE_MIN = 2'd1,
		ACT_REMOVE_ID = 2'd2,
		ACT_REBASE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_DONE = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL = 2'd2,
		STS_DUPLICATE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_EXEC,
		ST_SORT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		C_HOLD,
		C_INSERT,
		C_SHIFT,
		C_REBASE,
		C_SORT
	} cell_op_t;

	// one queue entry
	typedef struct packed {
		logic valid;
		logic [ID_W-1:0] id;
		logic [RT_W-1:0] rt;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		cell_op_t op;
		entry_t new_entry;
		entry_t mkey;
		logic shift_all;
		logic [RT_W-1:0] amount;
	} cell_cmd_t;

	// key order: runtime first, then id
	function automatic logic key_lt(entry_t a, entry_t b);
		return (a.rt < b.rt) || ((a.rt == b.rt) && (a.id < b.id));
	endfunction

	function automatic logic [RT_W-1:0] clamp_sub(logic [RT_W-1:0] v, logic [RT_W-1:0] amt);
		return (v >= amt) ? (v - amt) : '0;
	endfunction

endpackage
`default_nettype wire

FILE: src/fsrq_if.sv
`default_nettype none
interface fsrq_in_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [15:0] thread_id;
	logic [63:0] vruntime;
	logic [63:0] rebase_amount;

	modport source (output valid, action, thread_id, vruntime, rebase_amount, input ready);
	modport sink (input valid, action, thread_id, vruntime, rebase_amount, output ready);
endinterface

interface fsrq_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [15:0] out_id;
	logic [63:0] out_vruntime;
	logic [6:0] count;
	logic [63:0] floor_vruntime;

	modport source (output valid, status, out_id, out_vruntime, count, floor_vruntime,
		input ready);
	modport sink (input valid, status, out_id, out_vruntime, count, floor_vruntime,
		output ready);
endinterface
`default_nettype wire

FILE: src/fsrq_cell.sv
`default_nettype none
module fsrq_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire fsrq_pkg::cell_cmd_t cmd,
	input wire fsrq_pkg::entry_t left,
	input wire logic left_lt,
	input wire logic left_gtr,
	input wire fsrq_pkg::entry_t right,
	input wire logic sort_left,
	output fsrq_pkg::entry_t q,
	output logic lt,
	output logic gtr
);
	import fsrq_pkg::*;

	entry_t entry_q;
	entry_t nxt;
	logic ge;

	assign q = entry_q;

	// neighbor flags: new word goes before this entry / right entry should come first
	assign lt = !entry_q.valid || key_lt(cmd.new_entry, entry_q);
	assign gtr = entry_q.valid && right.valid && key_lt(right, entry_q);
	assign ge = entry_q.valid && !key_lt(entry_q, cmd.mkey);

	always_comb begin
		nxt = entry_q;
		case (cmd.op)
			C_INSERT: begin
				if (left_lt) begin
					nxt = left;
				end else if (lt) begin
					nxt = cmd.new_entry;
				end
			end
			C_SHIFT: begin
				if (cmd.shift_all || ge) begin
					nxt = right;
				end
			end
			C_REBASE: begin
				nxt.rt = clamp_sub(entry_q.rt, cmd.amount);
			end
			C_SORT: begin
				if (sort_left) begin
					if (gtr) begin
						nxt = right;
					end
				end else if (left_gtr) begin
					nxt = left;
				end
			end
			default: begin
				nxt = entry_q;
			end
		endcase
	end

	// entry register; valid clears on reset, payload with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: src/fair_share_run_queue.sv
// Fair-share run queue: a sorted chain of cells, smallest key in cell 0.
// Per item: the accepted word is latched, then the FIND, EXEC and DONE states run and the result
// word is registered; a rebase that changes runtimes adds odd-even sort passes in ST_SORT.
// One item at a time: a new word is taken only once the block is idle again.
// Reset (arst_n, asynchronous): queue empty, count and floor zero, no result pending.
`default_nettype none
module fair_share_run_queue #(
	parameter int CAPACITY = fsrq_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fsrq_in_if.sink req,
	fsrq_out_if.source rsp
);
	import fsrq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(CAPACITY);

	state_t state_q, state_d;

	// latched request
	action_t act_q;
	logic [ID_W-1:0] id_q;
	logic [RT_W-1:0] vr_q;
	logic [RT_W-1:0] amt_q;

	logic found_q;
	entry_t mkey_q;
	logic [CW-1:0] count_q;
	logic [RT_W-1:0] floor_q;
	logic raise_q;
	logic [SW-1:0] sort_cnt_q;
	status_t sts_q;
	logic [ID_W-1:0] res_id_q;
	logic [RT_W-1:0] res_rt_q;

	logic out_valid_q;
	status_t out_sts_q;
	logic [ID_W-1:0] out_id_q;
	logic [RT_W-1:0] out_rt_q;
	logic [CW-1:0] out_cnt_q;
	logic [RT_W-1:0] out_floor_q;

	cell_cmd_t cmd;
	entry_t cells [CAPACITY];
	entry_t lefts [CAPACITY];
	entry_t rights [CAPACITY];
	logic lt_v [CAPACITY];
	logic gtr_v [CAPACITY];
	logic left_lt_v [CAPACITY];
	logic left_gtr_v [CAPACITY];
	logic sort_left_v [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	logic [CAPACITY-1:0] match_vec;
	entry_t mkey_d;
	logic full;
	logic ins_ok;
	logic out_free;
	logic head_ordered;
	logic [RT_W-1:0] floor_raised;

	assign full = (count_q == CW'(CAPACITY));
	assign ins_ok = !found_q && !full;
	assign out_free = !out_valid_q || rsp.ready;

	// the chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lefts[i] = '0;
			assign left_lt_v[i] = 1'b0;
			assign left_gtr_v[i] = 1'b0;
		end else begin : g_mid
			assign lefts[i] = cells[i-1];
			assign left_lt_v[i] = lt_v[i-1];
			assign left_gtr_v[i] = gtr_v[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rights[i] = '0;
		end else begin : g_inner
			assign rights[i] = cells[i+1];
		end
		assign sort_left_v[i] = (i % 2 == 1) ? sort_cnt_q[0] : !sort_cnt_q[0];
		assign valid_vec[i] = cells[i].valid;
		assign match_vec[i] = cells[i].valid && (cells[i].id == id_q);

		fsrq_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.left(lefts[i]),
			.left_lt(left_lt_v[i]),
			.left_gtr(left_gtr_v[i]),
			.right(rights[i]),
			.sort_left(sort_left_v[i]),
			.q(cells[i]),
			.lt(lt_v[i]),
			.gtr(gtr_v[i])
		);
	end

	// key of the entry holding the requested id (ids are unique)
	always_comb begin
		mkey_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_vec[i]) begin
				mkey_d = mkey_d | cells[i];
			end
		end
	end

	assign floor_raised = (raise_q && cells[0].valid && (cells[0].rt > floor_q)) ?
		cells[0].rt : floor_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = (act_q == ACT_REBASE && amt_q != '0 && count_q != '0) ?
					ST_SORT : ST_DONE;
			end
			ST_SORT: begin
				if (sort_cnt_q == SW'(CAPACITY - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer: ready and cell command
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		cmd.op = C_HOLD;
		cmd.new_entry = '{valid: 1'b1, id: id_q, rt: vr_q};
		cmd.mkey = mkey_q;
		cmd.shift_all = (act_q == ACT_REMOVE_MIN);
		cmd.amount = amt_q;
		case (state_q)
			ST_EXEC: begin
				case (act_q)
					ACT_INSERT: cmd.op = ins_ok ? C_INSERT : C_HOLD;
					ACT_REMOVE_MIN: cmd.op = cells[0].valid ? C_SHIFT : C_HOLD;
					ACT_REMOVE_ID: cmd.op = found_q ? C_SHIFT : C_HOLD;
					ACT_REBASE: cmd.op = (amt_q != '0 && count_q != '0) ? C_REBASE : C_HOLD;
					default: cmd.op = C_HOLD;
				endcase
			end
			ST_SORT: begin
				cmd.op = C_SORT;
			end
			default: begin
				cmd.op = C_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// occupancy, floor and sort-pass bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			floor_q <= '0;
			raise_q <= 1'b0;
			sort_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_EXEC: begin
					raise_q <= 1'b0;
					sort_cnt_q <= '0;
					case (act_q)
						ACT_INSERT: begin
							if (ins_ok) begin
								count_q <= count_q + CW'(1);
								raise_q <= 1'b1;
							end
						end
						ACT_REMOVE_MIN: begin
							if (cells[0].valid) begin
								count_q <= count_q - CW'(1);
								raise_q <= 1'b1;
							end
						end
						ACT_REMOVE_ID: begin
							if (found_q) begin
								count_q <= count_q - CW'(1);
								raise_q <= 1'b1;
							end
						end
						ACT_REBASE: begin
							if (amt_q != '0 && count_q != '0) begin
								floor_q <= clamp_sub(floor_q, amt_q);
							end
						end
						default: begin
							raise_q <= 1'b0;
						end
					endcase
				end
				ST_SORT: begin
					sort_cnt_q <= sort_cnt_q + SW'(1);
				end
				ST_DONE: begin
					if (out_free) begin
						floor_q <= floor_raised;
						raise_q <= 1'b0;
					end
				end
				default: begin
					raise_q <= raise_q;
				end
			endcase
		end
	end

	// payload registers of the item in flight
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q <= action_t'(req.action);
			id_q <= req.thread_id;
			vr_q <= req.vruntime;
			amt_q <= req.rebase_amount;
		end
		if (state_q == ST_FIND) begin
			found_q <= |match_vec;
			mkey_q <= mkey_d;
		end
		if (state_q == ST_EXEC) begin
			sts_q <= STS_DONE;
			res_id_q <= '0;
			res_rt_q <= '0;
			case (act_q)
				ACT_INSERT: begin
					if (found_q) begin
						sts_q <= STS_DUPLICATE;
					end else if (full) begin
						sts_q <= STS_FULL;
					end
				end
				ACT_REMOVE_MIN: begin
					if (cells[0].valid) begin
						res_id_q <= cells[0].id;
						res_rt_q <= cells[0].rt;
					end else begin
						sts_q <= STS_NOT_FOUND;
					end
				end
				ACT_REMOVE_ID: begin
					if (!found_q) begin
						sts_q <= STS_NOT_FOUND;
					end
				end
				default: begin
					sts_q <= STS_DONE;
				end
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_sts_q <= sts_q;
			out_id_q <= res_id_q;
			out_rt_q <= res_rt_q;
			out_cnt_q <= count_q;
			out_floor_q <= floor_raised;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_sts_q;
	assign rsp.out_id = out_id_q;
	assign rsp.out_vruntime = out_rt_q;
	assign rsp.count = CNT_OUT_W'(out_cnt_q);
	assign rsp.floor_vruntime = out_floor_q;

	assign head_ordered = !valid_vec[1] || !key_lt(cells[1], cells[0]);

	// occupancy never exceeds the chain length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("occupancy beyond capacity");

	// between items the valid cells match the count
	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> $countones(valid_vec) == int'(count_q))
		else $error("valid cells disagree with count");

	// between items a valid second cell implies a valid head cell
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && valid_vec[1] |-> valid_vec[0])
		else $error("hole at head of chain");

	// between items the head key is not larger than the key of the second cell
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> head_ordered)
		else $error("head entries out of order");

	// a raise leaves the floor at or above the head runtime
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free && raise_q && valid_vec[0]
		|=> floor_q >= cells[0].rt)
		else $error("floor below head runtime after raise");

	// a result word waiting for the sink stays valid and keeps its floor
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q && $stable(out_floor_q))
		else $error("pending result changed");

endmodule
`default_nettype wire

FILE: bench/tb_fair_share_run_queue.sv
`timescale 1ns / 1ps
module tb_fair_share_run_queue;
	import fsrq_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int RAND_ITEMS = 550;
	localparam int STALL_LIMIT = 2000;
	localparam logic [63:0] RT_MAX = '1;
	localparam logic [15:0] ID_MAX = '1;

	typedef struct {
		action_t act;
		logic [15:0] id;
		logic [63:0] vr;
		logic [63:0] amt;
	} sched_req_t;

	typedef struct {
		status_t st;
		logic [15:0] oid;
		logic [63:0] ovr;
		logic [6:0] cnt;
		logic [63:0] flr;
	} sched_rsp_t;

	typedef struct {
		sched_req_t w;
		bit typed;
		sched_rsp_t r;
	} dir_row_t;

	typedef enum {MIX_GROW, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

	logic clk = 1'b0;
	logic arst_n;

	fsrq_in_if req_if();
	fsrq_out_if rsp_if();

	fair_share_run_queue #(.CAPACITY(CAP)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the run queue
	bit rq_valid[CAP];
	logic [15:0] rq_id[CAP];
	logic [63:0] rq_rt[CAP];
	int rq_occ;
	logic [63:0] rq_floor;

	// results still owed by the block, oldest first
	sched_rsp_t pending[$];

	int n_fail = 0;
	int n_checked = 0;
	int burst_left = 0;
	int n_act[4];
	int n_full = 0;
	int n_dup = 0;
	int n_miss = 0;
	int peak_occ = 0;

	function automatic int rq_find(input logic [15:0] id);
		for (int i = 0; i < CAP; i++)
			if (rq_valid[i] && rq_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic int rq_min_slot();
		int best = -1;
		for (int i = 0; i < CAP; i++) begin
			if (rq_valid[i] && (best < 0 || rq_rt[i] < rq_rt[best] ||
					(rq_rt[i] == rq_rt[best] && rq_id[i] < rq_id[best])))
				best = i;
		end
		return best;
	endfunction

	function automatic void rq_raise_floor();
		int m;
		m = rq_min_slot();
		if (m >= 0 && rq_rt[m] > rq_floor)
			rq_floor = rq_rt[m];
	endfunction

	// random queued slot, -1 when empty
	function automatic int rq_pick_slot();
		int idx[$];
		for (int i = 0; i < CAP; i++)
			if (rq_valid[i])
				idx.push_back(i);
		if (idx.size() == 0)
			return -1;
		return idx[$urandom_range(0, idx.size() - 1)];
	endfunction

	// apply one word to the shadow queue and return the result it must produce
	function automatic sched_rsp_t rq_predict(input sched_req_t w);
		sched_rsp_t r;
		int s;
		r.st = STS_DONE;
		r.oid = '0;
		r.ovr = '0;
		case (w.act)
			ACT_INSERT: begin
				if (rq_find(w.id) >= 0) begin
					r.st = STS_DUPLICATE;
				end else begin
					s = -1;
					for (int i = 0; i < CAP; i++)
						if (!rq_valid[i] && s < 0)
							s = i;
					if (s < 0) begin
						r.st = STS_FULL;
					end else begin
						rq_valid[s] = 1'b1;
						rq_id[s] = w.id;
						rq_rt[s] = w.vr;
						rq_occ++;
						rq_raise_floor();
					end
				end
			end
			ACT_REMOVE_MIN: begin
				s = rq_min_slot();
				if (s < 0) begin
					r.st = STS_NOT_FOUND;
				end else begin
					r.oid = rq_id[s];
					r.ovr = rq_rt[s];
					rq_valid[s] = 1'b0;
					rq_occ--;
					rq_raise_floor();
				end
			end
			ACT_REMOVE_ID: begin
				s = rq_find(w.id);
				if (s < 0) begin
					r.st = STS_NOT_FOUND;
				end else begin
					rq_valid[s] = 1'b0;
					rq_occ--;
					rq_raise_floor();
				end
			end
			default: begin
				// clamped subtraction, floor not raised afterwards
				if (w.amt != 0 && rq_occ != 0) begin
					for (int i = 0; i < CAP; i++)
						if (rq_valid[i])
							rq_rt[i] = (rq_rt[i] >= w.amt) ? rq_rt[i] - w.amt : '0;
					rq_floor = (rq_floor >= w.amt) ? rq_floor - w.amt : '0;
				end
			end
		endcase
		r.cnt = 7'(rq_occ);
		r.flr = rq_floor;
		return r;
	endfunction

	function automatic dir_row_t mk_row(input action_t act, input logic [15:0] id,
			input logic [63:0] vr, input logic [63:0] amt, input bit typed,
			input status_t st, input logic [15:0] oid, input logic [63:0] ovr,
			input logic [6:0] cnt, input logic [63:0] flr);
		dir_row_t d;
		d.w.act = act;
		d.w.id = id;
		d.w.vr = vr;
		d.w.amt = amt;
		d.typed = typed;
		d.r.st = st;
		d.r.oid = oid;
		d.r.ovr = ovr;
		d.r.cnt = cnt;
		d.r.flr = flr;
		return d;
	endfunction

	function automatic void note_fail(input string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("FAIL %0d: %s", n_fail, msg);
	endfunction

	// send one word in the sender's burst pattern, then queue its expected result
	task automatic send_item(input sched_req_t w, input bit typed, input sched_rsp_t typed_rsp);
		int gap;
		sched_rsp_t res;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 10);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.action <= w.act;
		req_if.thread_id <= w.id;
		req_if.vruntime <= w.vr;
		req_if.rebase_amount <= w.amt;
		do @(posedge clk); while (!req_if.ready);
		res = rq_predict(w);
		n_act[w.act]++;
		case (res.st)
			STS_FULL: n_full++;
			STS_DUPLICATE: n_dup++;
			STS_NOT_FOUND: n_miss++;
			default: ;
		endcase
		if (rq_occ > peak_occ)
			peak_occ = rq_occ;
		pending.push_back(typed ? typed_rsp : res);
	endtask

	// receiver: rotating ready pattern, replaced by a new random pattern after a random hold
	initial begin : rsp_stall
		logic [15:0] pat;
		int hold;
		rsp_if.ready = 1'b0;
		pat = '1;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				case ($urandom_range(0, 3))
					0: pat = '1;
					1: pat = 16'($urandom) | 16'h0001;
					2: pat = 16'h1 << $urandom_range(0, 15);
					default: pat = 16'h5555;
				endcase
				hold = $urandom_range(50, 300);
			end
			hold--;
			rsp_if.ready <= pat[0];
			pat = {pat[0], pat[15:1]};
		end
	end

	// result checker
	always @(posedge clk) begin : rsp_check
		sched_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending.size() == 0) begin
				note_fail($sformatf("unexpected result st=%0d id=%h cnt=%0d",
					rsp_if.status, rsp_if.out_id, rsp_if.count));
			end else begin
				want = pending.pop_front();
				n_checked++;
				if (rsp_if.status !== want.st || rsp_if.out_id !== want.oid ||
						rsp_if.out_vruntime !== want.ovr || rsp_if.count !== want.cnt ||
						rsp_if.floor_vruntime !== want.flr)
					note_fail($sformatf({"result %0d: want st=%0d id=%h vr=%h cnt=%0d fl=%h",
						", got st=%0d id=%h vr=%h cnt=%0d fl=%h"}, n_checked,
						want.st, want.oid, want.ovr, want.cnt, want.flr,
						rsp_if.status, rsp_if.out_id, rsp_if.out_vruntime,
						rsp_if.count, rsp_if.floor_vruntime));
			end
		end
	end

	// watchdog: too long without any word moving on either side
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout after %0d idle cycles, %0d results pending", idle, pending.size());
		$display("tb_fair_share_run_queue: errors");
		$finish;
	end

	initial begin : stimulus
		dir_row_t dir_tab[$];
		sched_req_t w;
		sched_rsp_t no_rsp;
		traffic_mix_t mix;
		int seg, seg_len, n_rand, pick, slot;
		int cut_ins, cut_min, cut_id;

		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_INSERT;
		req_if.thread_id = '0;
		req_if.vruntime = '0;
		req_if.rebase_amount = '0;
		for (int i = 0; i < CAP; i++)
			rq_valid[i] = 1'b0;
		rq_occ = 0;
		rq_floor = '0;
		for (int i = 0; i < 4; i++)
			n_act[i] = 0;
		no_rsp.st = STS_DONE;
		no_rsp.oid = '0;
		no_rsp.ovr = '0;
		no_rsp.cnt = '0;
		no_rsp.flr = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty queue, extremes, duplicate, zero rebase, clamping and id order
		dir_tab.push_back(mk_row(ACT_REMOVE_MIN, 0, 0, 0, 1, STS_NOT_FOUND, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REMOVE_ID, 0, 0, 0, 1, STS_NOT_FOUND, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REBASE, 0, 0, RT_MAX, 1, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_INSERT, ID_MAX, RT_MAX, 0, 1, STS_DONE, 0, 0, 1, RT_MAX));
		dir_tab.push_back(mk_row(ACT_INSERT, ID_MAX, 0, 0, 1, STS_DUPLICATE, 0, 0, 1, RT_MAX));
		dir_tab.push_back(mk_row(ACT_INSERT, 0, 0, 0, 1, STS_DONE, 0, 0, 2, RT_MAX));
		dir_tab.push_back(mk_row(ACT_REMOVE_MIN, 0, 0, 0, 1, STS_DONE, 0, 0, 1, RT_MAX));
		dir_tab.push_back(mk_row(ACT_REBASE, 0, 0, 0, 1, STS_DONE, 0, 0, 1, RT_MAX));
		dir_tab.push_back(mk_row(ACT_REBASE, 0, 0, 1, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_INSERT, 5, 10, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_INSERT, 3, 10, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_INSERT, 7, 5, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REMOVE_MIN, 0, 0, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REBASE, 0, 0, RT_MAX, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_INSERT, 1, 0, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REMOVE_MIN, 0, 0, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REMOVE_MIN, 0, 0, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REMOVE_ID, ID_MAX, 0, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REMOVE_ID, 16'h1234, 0, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REBASE, 0, 0, 64'h8000_0000_0000_0000, 0,
			STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_INSERT, 16'hAAAA, 64'h5555_5555_5555_5555, 0, 0,
			STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_INSERT, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0,
			STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REBASE, 0, 0, 64'h5555_5555_5555_5555, 0,
			STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REMOVE_MIN, 0, 0, 0, 0, STS_DONE, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_REMOVE_MIN, 0, 0, 0, 0, STS_DONE, 0, 0, 0, 0));
		foreach (dir_tab[i])
			send_item(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);

		// random: segments biased toward filling, draining or churning the queue;
		// the first one is long enough to run into the full queue
		n_rand = 0;
		seg = 0;
		while (n_rand < RAND_ITEMS) begin
			if (seg == 0) begin
				mix = MIX_GROW;
				seg_len = 150;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					mix = MIX_GROW;
				else if (pick < 7)
					mix = MIX_DRAIN;
				else
					mix = MIX_EVEN;
				seg_len = $urandom_range(30, 120);
			end
			seg++;
			case (mix)
				MIX_GROW: begin cut_ins = 80; cut_min = 87; cut_id = 95; end
				MIX_DRAIN: begin cut_ins = 15; cut_min = 55; cut_id = 90; end
				default: begin cut_ins = 35; cut_min = 60; cut_id = 85; end
			endcase
			for (int k = 0; k < seg_len && n_rand < RAND_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < cut_ins)
					w.act = ACT_INSERT;
				else if (pick < cut_min)
					w.act = ACT_REMOVE_MIN;
				else if (pick < cut_id)
					w.act = ACT_REMOVE_ID;
				else
					w.act = ACT_REBASE;
				// unused fields still carry random bits
				w.id = 16'($urandom);
				w.vr = {$urandom, $urandom};
				w.amt = {$urandom, $urandom};
				slot = rq_pick_slot();
				case (w.act)
					ACT_INSERT: begin
						pick = $urandom_range(0, 9);
						if (pick < 2 && slot >= 0)
							w.id = rq_id[slot];
						else if (pick < 5)
							w.id = $urandom_range(0, 1) ? 16'($urandom_range(0, 47)) :
								ID_MAX - 16'($urandom_range(0, 47));
						case ($urandom_range(0, 9))
							0: w.vr = '0;
							1: w.vr = RT_MAX;
							2, 3: w.vr = rq_floor + 64'($urandom_range(0, 1000));
							4: w.vr = rq_floor - 64'($urandom_range(1, 1000));
							5: if (slot >= 0) w.vr = rq_rt[slot];
							default: w.vr = {$urandom, $urandom} >> $urandom_range(0, 63);
						endcase
					end
					ACT_REMOVE_ID: begin
						if (slot >= 0 && $urandom_range(0, 9) < 7)
							w.id = rq_id[slot];
						else if ($urandom_range(0, 1))
							w.id = 16'($urandom_range(0, 47));
					end
					ACT_REBASE: begin
						case ($urandom_range(0, 9))
							0: w.amt = '0;
							1: w.amt = RT_MAX;
							2, 3: w.amt = 64'($urandom_range(1, 1000));
							4: w.amt = rq_floor;
							5: if (slot >= 0) w.amt = rq_rt[slot];
							default: w.amt = {$urandom, $urandom} >> $urandom_range(0, 63);
						endcase
					end
					default: ;
				endcase
				send_item(w, 0, no_rsp);
				n_rand++;
			end
		end
		req_if.valid <= 1'b0;

		// drain, then give a late rebase sort time to show stray words
		while (pending.size() != 0)
			@(posedge clk);
		repeat (CAP + 16) @(posedge clk);

		$display("run covered %0d insert, %0d remove-min, %0d remove-id, %0d rebase words",
			n_act[ACT_INSERT], n_act[ACT_REMOVE_MIN], n_act[ACT_REMOVE_ID], n_act[ACT_REBASE]);
		$display("full %0d, duplicate %0d, empty/missing %0d, peak depth %0d, %0d results checked",
			n_full, n_dup, n_miss, peak_occ, n_checked);
		if (n_fail == 0) begin
			$display("tb_fair_share_run_queue: clean");
		end else begin
			$display("%0d failures", n_fail);
			$display("tb_fair_share_run_queue: errors");
		end
		$finish;
	end

endmodule

FILE: fair_share_run_queue.f
src/fsrq_pkg.sv
src/fsrq_if.sv
src/fsrq_cell.sv
src/fair_share_run_queue.sv
bench/tb_fair_share_run_queue.sv
